/* rtl/bqlp_pkg.sv */
// Shared types and constants for the biquad low-pass filter unit.
// No dependencies; imported by every module of the block.
package bqlp_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int COEF_W    = 16;
	localparam int FRAC_BITS = COEF_W - 2;
	localparam int PROD_W    = SAMPLE_W + COEF_W;
	// Five products summed need three guard bits.
	localparam int ACC_W     = PROD_W + 3;
	localparam int RES_W     = ACC_W - FRAC_BITS;
	localparam int NUM_REGS  = 5;
	localparam int IDX_W     = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_FEED_0 = 3'd0,
		REG_FEED_1 = 3'd1,
		REG_FEED_2 = 3'd2,
		REG_BACK_1 = 3'd3,
		REG_BACK_2 = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] feed_0;
		logic signed [COEF_W-1:0] feed_1;
		logic signed [COEF_W-1:0] feed_2;
		logic signed [COEF_W-1:0] back_1;
		logic signed [COEF_W-1:0] back_2;
	} coef_set_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] x1;
		logic signed [SAMPLE_W-1:0] x2;
		logic signed [SAMPLE_W-1:0] y1;
		logic signed [SAMPLE_W-1:0] y2;
	} hist_t;

endpackage

/* rtl/bqlp_coef_regs.sv */
// Coefficient register file of the biquad filter, written through a plain write port.
// Depends on bqlp_pkg.
module bqlp_coef_regs
	import bqlp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [COEF_W-1:0] cfg_wdata,
	output coef_set_t         coef
);

	coef_set_t coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_FEED_0: coef_q.feed_0 <= cfg_wdata;
				REG_FEED_1: coef_q.feed_1 <= cfg_wdata;
				REG_FEED_2: coef_q.feed_2 <= cfg_wdata;
				REG_BACK_1: coef_q.back_1 <= cfg_wdata;
				REG_BACK_2: coef_q.back_2 <= cfg_wdata;
				default: ; // Writes beyond the last register are dropped.
			endcase
		end
	end

	assign coef = coef_q;

endmodule

/* rtl/bqlp_mac.sv */
// Combinational biquad datapath: five parallel products, sum, rounding and saturation.
// Depends on bqlp_pkg.
module bqlp_mac
	import bqlp_pkg::*;
(
	input  coef_set_t                  coef,
	input  hist_t                      hist,
	input  logic                       clear,
	input  logic signed [SAMPLE_W-1:0] x,
	output logic signed [SAMPLE_W-1:0] y,
	output logic                       sat
);

	hist_t                    h;
	logic signed [PROD_W-1:0] p0, p1, p2, p3, p4;
	logic signed [ACC_W-1:0]  acc;
	logic signed [ACC_W-1:0]  acc_rnd;
	logic signed [RES_W-1:0]  res;
	logic                     sat_hi;
	logic                     sat_lo;

	// A clear request filters this item against an empty history.
	assign h = clear ? '0 : hist;

	assign p0 = coef.feed_0 * x;
	assign p1 = coef.feed_1 * h.x1;
	assign p2 = coef.feed_2 * h.x2;
	assign p3 = coef.back_1 * h.y1;
	assign p4 = coef.back_2 * h.y2;

	assign acc = ACC_W'(p0) + ACC_W'(p1) + ACC_W'(p2) - ACC_W'(p3) - ACC_W'(p4);
	assign acc_rnd = acc + (ACC_W'(1) <<< (FRAC_BITS - 1));
	assign res = RES_W'(acc_rnd >>> FRAC_BITS);

	// Out of range when the bits above the sample's sign differ from the sign.
	assign sat_hi = !res[RES_W-1] && (|res[RES_W-2:SAMPLE_W-1]);
	assign sat_lo = res[RES_W-1] && !(&res[RES_W-2:SAMPLE_W-1]);
	assign sat    = sat_hi || sat_lo;

	always_comb begin
		if (sat_hi) begin
			y = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end else if (sat_lo) begin
			y = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			y = res[SAMPLE_W-1:0];
		end
	end

endmodule

/* rtl/biquad_lowpass_filter_unit.sv */
// Top level of the biquad low-pass filter: input register, datapath, history and output register.
// Depends on bqlp_pkg, bqlp_coef_regs and bqlp_mac.
//
// Usage:
//   Samples enter on the s_ stream channel: s_tdata carries the signed sample,
//   s_tuser the clear-history flag. Each item yields exactly one filtered sample
//   on the m_ stream channel: m_tdata carries the sample, m_tuser the saturation
//   flag. Coefficients (Q2.14) are written through cfg_wr_en / cfg_index /
//   cfg_wdata while the block is idle; each write takes effect at once.
//   Throughput is one item per cycle while m_tready stays high: the input register,
//   the combinational multiply-add datapath and the output register form a
//   two-stage pipeline, and the previous output feeds back through the history registers.
//   An accepted item waits in the input register, then passes through the datapath
//   into the output register, which drives m_tvalid.
//   When the receiver stalls, the output register holds its item and the input
//   register can still take one more item before s_tready drops.
//   Reset clears the coefficients, the history and both valid flags.
module biquad_lowpass_filter_unit
	import bqlp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [SAMPLE_W-1:0] s_tdata,   // [15:0] sample_in
	input  logic                s_tuser,   // [0] clear_history
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [SAMPLE_W-1:0] m_tdata,   // [15:0] sample_out
	output logic                m_tuser,   // [0] saturated
	input  logic                cfg_wr_en,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [COEF_W-1:0]   cfg_wdata
);

	coef_set_t                  coef;
	hist_t                      hist_q;
	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] x_s1;
	logic                       clear_s1;
	logic                       out_valid_q;
	logic [SAMPLE_W-1:0]        out_data_q;
	logic                       out_sat_q;
	logic signed [SAMPLE_W-1:0] y;
	logic                       sat;
	logic                       advance;

	bqlp_coef_regs u_coef_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.coef      (coef)
	);

	bqlp_mac u_mac (
		.coef  (coef),
		.hist  (hist_q),
		.clear (clear_s1),
		.x     (x_s1),
		.y     (y),
		.sat   (sat)
	);

	// The input stage moves on when the output register is empty or being emptied.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			x_s1     <= s_tdata;
			clear_s1 <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (advance) begin
			hist_q.x2 <= clear_s1 ? '0 : hist_q.x1;
			hist_q.x1 <= x_s1;
			hist_q.y2 <= clear_s1 ? '0 : hist_q.y1;
			hist_q.y1 <= y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= y;
			out_sat_q  <= sat;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_sat_q;

endmodule
